FILE: sv/npcm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npcm_pkg
// Shared types, register indexes and the distance function for the
// nearest palette color matcher.
// ----------------------------------------------------------------------------
package npcm_pkg;

	localparam int PIX_W     = 15;
	localparam int CODE_W    = 8;
	localparam int CHAN_W    = 5;
	localparam int DIST_W    = 12;   // 3 * 31^2 = 2883
	localparam int SLOTS     = 16;   // palette storage, four entries per word
	localparam int WORD_W    = 60;
	localparam int WORDS     = 4;
	localparam int CFG_IDX_W = 3;
	localparam int COUNT_W   = 5;

	localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CONVERT_MODE  = 3'd0,
		CFG_PALETTE_COUNT = 3'd1,
		CFG_PALETTE_WORD_A = 3'd2,
		CFG_PALETTE_WORD_B = 3'd3,
		CFG_PALETTE_WORD_C = 3'd4,
		CFG_PALETTE_WORD_D = 3'd5
	} cfg_reg_t;

	// One pixel in flight along the chain of cells.
	typedef struct packed {
		logic              valid;
		logic [PIX_W-1:0]  pixel;
		logic              found;
		logic [DIST_W-1:0] best;
		logic [CODE_W-1:0] code;
	} npcm_beat_t;

	function automatic logic [2*CHAN_W-1:0] sq_diff(
		input logic [CHAN_W-1:0] a,
		input logic [CHAN_W-1:0] b
	);
		logic [CHAN_W-1:0] d;
		d = (a > b) ? (a - b) : (b - a);
		return (2*CHAN_W)'(d) * (2*CHAN_W)'(d);
	endfunction

	// Squared RGB distance between two RGB555 colors.
	function automatic logic [DIST_W-1:0] color_dist(
		input logic [PIX_W-1:0] x,
		input logic [PIX_W-1:0] y
	);
		return DIST_W'(sq_diff(x[14:10], y[14:10]))
		     + DIST_W'(sq_diff(x[9:5], y[9:5]))
		     + DIST_W'(sq_diff(x[4:0], y[4:0]));
	endfunction

endpackage

FILE: sv/npcm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npcm_cell
// One comparison cell: measures the passing pixel against its palette entry
// and keeps the better candidate before handing the beat on.
// ----------------------------------------------------------------------------
module npcm_cell #(
	parameter int IDX = 0
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       advance,
	input  logic                       enable,
	input  logic [npcm_pkg::PIX_W-1:0] entry,
	input  npcm_pkg::npcm_beat_t       beat_in,
	output npcm_pkg::npcm_beat_t       beat_out
);
	import npcm_pkg::*;

	logic [DIST_W-1:0] entry_dist;
	logic              take;
	npcm_beat_t        beat_q;

	assign entry_dist = color_dist(entry, beat_in.pixel);
	// strictly smaller only, so the earlier entry wins a tie
	assign take = enable && (!beat_in.found || (entry_dist < beat_in.best));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q <= '0;
		end else if (advance) begin
			beat_q.valid <= beat_in.valid;
			beat_q.pixel <= beat_in.pixel;
			beat_q.found <= beat_in.found || take;
			beat_q.best  <= take ? entry_dist : beat_in.best;
			beat_q.code  <= take ? CODE_W'(IDX) : beat_in.code;
		end
	end

	assign beat_out = beat_q;

endmodule

FILE: sv/nearest_palette_color_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_palette_color_match
// Maps an RGB555 pixel to an 8-bit code: nearest palette index or a packed
// GRB332 byte, through a chain of one comparison cell per palette entry.
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  pixel     pix_valid / pix_stall     pixel_color [14:0]
//  code      code_valid / code_stall   color_code [7:0]
//  config    cfg_valid / cfg_ready     cfg_index [2:0], cfg_data [59:0]
//
//  One pixel enters per cycle unless the chain is held; its code is registered
//  in each of the PALETTE_ENTRIES cells in turn, and one code leaves per cycle.
//  A stall of a valid code beat freezes the whole chain and stalls the pixel side.
//  Reset empties the chain and loads the register reset values; cfg_ready is
//  always high.
// ----------------------------------------------------------------------------
module nearest_palette_color_match #(
	parameter int PALETTE_ENTRIES = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           pix_valid,
	output logic                           pix_stall,
	input  logic [npcm_pkg::PIX_W-1:0]     pixel_color,
	output logic                           code_valid,
	input  logic                           code_stall,
	output logic [npcm_pkg::CODE_W-1:0]    color_code,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [npcm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [npcm_pkg::WORD_W-1:0]    cfg_data
);
	import npcm_pkg::*;

	logic               convert_mode_q;
	logic [COUNT_W-1:0] palette_count_q;
	logic [WORD_W-1:0]  pal_word_q [WORDS];
	logic [PIX_W-1:0]   pal_entry [SLOTS];
	npcm_beat_t         chain [PALETTE_ENTRIES+1];
	logic               advance;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			convert_mode_q  <= 1'b0;
			palette_count_q <= COUNT_RESET;
			for (int w = 0; w < WORDS; w++) begin
				pal_word_q[w] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_CONVERT_MODE:   convert_mode_q  <= cfg_data[0];
				CFG_PALETTE_COUNT:  palette_count_q <= cfg_data[COUNT_W-1:0];
				CFG_PALETTE_WORD_A: pal_word_q[0]   <= cfg_data;
				CFG_PALETTE_WORD_B: pal_word_q[1]   <= cfg_data;
				CFG_PALETTE_WORD_C: pal_word_q[2]   <= cfg_data;
				CFG_PALETTE_WORD_D: pal_word_q[3]   <= cfg_data;
				default: ;   // drop writes to unknown registers
			endcase
		end
	end

	for (genvar k = 0; k < SLOTS; k++) begin : g_entry
		assign pal_entry[k] = pal_word_q[k / 4][(k % 4) * PIX_W +: PIX_W];
	end

	// hold the whole chain while the finished code waits
	assign advance   = !(chain[PALETTE_ENTRIES].valid && code_stall);
	assign pix_stall = !advance;

	always_comb begin
		chain[0].valid = pix_valid;
		chain[0].pixel = pixel_color;
		chain[0].found = 1'b0;
		chain[0].best  = '0;
		chain[0].code  = convert_mode_q
		               ? {pixel_color[9:7], pixel_color[14:12], pixel_color[4:3]}
		               : '0;
	end

	for (genvar g = 0; g < PALETTE_ENTRIES; g++) begin : g_cell
		logic cell_en;
		assign cell_en = !convert_mode_q && (palette_count_q > COUNT_W'(g));

		npcm_cell #(
			.IDX(g)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.enable  (cell_en),
			.entry   (pal_entry[g]),
			.beat_in (chain[g]),
			.beat_out(chain[g+1])
		);
	end

	assign code_valid = chain[PALETTE_ENTRIES].valid;
	assign color_code = chain[PALETTE_ENTRIES].code;

endmodule

FILE: sv/npcm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npcm_checker
// Port-level checks for the nearest palette color matcher.
// ----------------------------------------------------------------------------
module npcm_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           pix_valid,
	input logic                           pix_stall,
	input logic                           code_valid,
	input logic                           code_stall,
	input logic [npcm_pkg::CODE_W-1:0]    color_code,
	input logic                           cfg_ready
);

	// a stalled code beat stays offered
	a_code_hold: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid && code_stall |=> code_valid)
		else $error("code beat dropped while stalled");

	// and its payload does not move
	a_code_stable: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid && code_stall |=> $stable(color_code))
		else $error("color_code changed while stalled");

	// the pixel side stalls only behind a blocked code beat
	a_pix_stall: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall == (code_valid && code_stall))
		else $error("pixel stall without blocked code beat");

	// an empty output frees the pixel and config inputs in the same cycle
	a_no_deadlock: assert property (@(posedge clk) disable iff (!arst_n)
		!code_valid |-> !pix_stall && cfg_ready)
		else $error("input blocked with empty output");

endmodule

bind nearest_palette_color_match npcm_checker u_npcm_checker (.*);
